>>> src/clns_pkg.sv
package clns_pkg;

    localparam int NUM_ROWS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int LINE_W     = 7;

    typedef logic [LINE_W-1:0] line_addr_t;

    localparam line_addr_t LINE_ADDR_0_RST = 7'd0;
    localparam line_addr_t LINE_ADDR_1_RST = 7'd64;
    localparam line_addr_t LINE_ADDR_2_RST = 7'd20;
    localparam line_addr_t LINE_ADDR_3_RST = 7'd84;

    typedef enum logic [1:0] {
        REG_LINE_ADDR_0 = 2'd0,
        REG_LINE_ADDR_1 = 2'd1,
        REG_LINE_ADDR_2 = 2'd2,
        REG_LINE_ADDR_3 = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_CLEAR = 3'd1,
        MODE_GOTO  = 3'd2,
        MODE_CMD   = 3'd3,
        MODE_DATA  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_CLEAR,
        JOB_BYTE
    } job_kind_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
    } cmd_t;

    typedef struct packed {
        logic        reg_select;
        logic        enable;
        logic [3:0]  nibble;
        logic [16:0] hold_cycles;
        logic        last;
    } evt_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] data;
    } job_t;

    localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0E;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [16:0] HOLD_HI_NIB = 17'd80;
    localparam logic [16:0] HOLD_LO_NIB = 17'd70;
    localparam logic [16:0] HOLD_TAIL   = 17'd150;
    localparam logic [16:0] HOLD_PWR_UP = 17'd100000;
    localparam logic [16:0] HOLD_PULSE  = 17'd30;
    localparam logic [16:0] HOLD_GAP    = 17'd30000;
    localparam logic [16:0] HOLD_CLEAR  = 17'd100000;

    typedef logic [5:0] step_t;

    // init script: power-up idle, wake pulses, setup bytes, then the clear bytes
    localparam step_t STEP_PULSE = 6'd1;
    localparam step_t STEP_BYTES = 6'd9;
    localparam step_t STEP_CLEAR = 6'd29;
    localparam step_t STEP_LAST  = 6'd36;
    localparam step_t WAKE_STEPS = 6'd6;

    function automatic logic [7:0] script_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_FUNC_SET;
            3'd1:    b = CMD_DISP_OFF;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_DISP_ON;
            3'd4:    b = CMD_ENTRY;
            3'd5:    b = CMD_CLEAR;
            default: b = CMD_SET_DDRAM;
        endcase
        return b;
    endfunction

    function automatic logic [16:0] script_extra(input logic [2:0] idx);
        logic [16:0] h;
        case (idx)
            3'd5:    h = HOLD_CLEAR;
            3'd6:    h = 17'd0;
            default: h = HOLD_GAP;
        endcase
        return h;
    endfunction

    function automatic evt_t job_event(input job_t job, input step_t step);
        evt_t        e;
        step_t       off;
        step_t       p;
        logic [1:0]  ph;
        logic [7:0]  byt;
        logic [16:0] extra;
        logic        is_byte;
        e       = '0;
        off     = step - STEP_BYTES;
        p       = step - STEP_PULSE;
        ph      = off[1:0];
        byt     = script_byte(off[4:2]);
        extra   = script_extra(off[4:2]);
        is_byte = 1'b1;
        if (job.kind == JOB_BYTE)
        begin
            ph           = step[1:0];
            byt          = job.data;
            extra        = 17'd0;
            e.reg_select = job.rs;
            e.last       = (step[1:0] == 2'd3);
        end
        else
        begin
            e.last = (step == STEP_LAST);
            if (step == '0)
            begin
                is_byte       = 1'b0;
                e.hold_cycles = HOLD_PWR_UP;
            end
            else if (step < STEP_BYTES)
            begin
                is_byte       = 1'b0;
                e.enable      = ~p[0];
                e.nibble      = (p < WAKE_STEPS) ? NIB_WAKE : NIB_4BIT;
                e.hold_cycles = p[0] ? (HOLD_PULSE + HOLD_GAP) : HOLD_PULSE;
            end
        end
        if (is_byte)
        begin
            e.enable = ~ph[0];
            e.nibble = ph[1] ? byt[3:0] : byt[7:4];
            case (ph)
                2'd0:    e.hold_cycles = HOLD_HI_NIB;
                2'd1:    e.hold_cycles = HOLD_HI_NIB;
                2'd2:    e.hold_cycles = HOLD_LO_NIB;
                default: e.hold_cycles = HOLD_LO_NIB + HOLD_TAIL + extra;
            endcase
        end
        return e;
    endfunction

endpackage

>>> src/clns_front.sv
module clns_front #(
    parameter int NUM_ROWS = clns_pkg::NUM_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  clns_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clns_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [clns_pkg::APB_DATA_W-1:0] pwdata,
    output logic [clns_pkg::APB_DATA_W-1:0] prdata,
    output logic                            push,
    output clns_pkg::job_t                  push_job,
    input  logic                            queue_full
);
    import clns_pkg::*;

    line_addr_t line_addr_0_reg, line_addr_0_next;
    line_addr_t line_addr_1_reg, line_addr_1_next;
    line_addr_t line_addr_2_reg, line_addr_2_next;
    line_addr_t line_addr_3_reg, line_addr_3_next;
    logic [1:0] cursor_row_reg, cursor_row_next;

    logic       accept;
    logic       wr;
    logic [2:0] inc_row;
    logic [1:0] wrap_row;
    logic [1:0] sel_row;
    logic [5:0] sel_col;
    line_addr_t sel_line;
    line_addr_t rd_line;
    logic [7:0] goto_byte;

    assign cmd_ready = !queue_full;
    assign accept    = cmd_valid && cmd_ready;
    assign wr        = psel && penable && pwrite;

    assign inc_row  = {1'b0, cursor_row_reg} + 3'd1;
    assign wrap_row = (inc_row >= 3'(NUM_ROWS)) ? 2'd0 : inc_row[1:0];
    assign sel_row  = (cmd.mode == MODE_DATA) ? wrap_row : cmd.row;
    assign sel_col  = (cmd.mode == MODE_DATA) ? 6'd0 : cmd.column;

    always_comb
    begin
        case (reg_idx_t'(sel_row))
            REG_LINE_ADDR_0: sel_line = line_addr_0_reg;
            REG_LINE_ADDR_1: sel_line = line_addr_1_reg;
            REG_LINE_ADDR_2: sel_line = line_addr_2_reg;
            default:         sel_line = line_addr_3_reg;
        endcase
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_LINE_ADDR_0: rd_line = line_addr_0_reg;
            REG_LINE_ADDR_1: rd_line = line_addr_1_reg;
            REG_LINE_ADDR_2: rd_line = line_addr_2_reg;
            default:         rd_line = line_addr_3_reg;
        endcase
    end

    assign prdata    = APB_DATA_W'(rd_line);
    assign goto_byte = CMD_SET_DDRAM | (8'(sel_col) + 8'(sel_line));

    always_comb
    begin
        line_addr_0_next = line_addr_0_reg;
        line_addr_1_next = line_addr_1_reg;
        line_addr_2_next = line_addr_2_reg;
        line_addr_3_next = line_addr_3_reg;
        if (wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_LINE_ADDR_0: line_addr_0_next = pwdata[LINE_W-1:0];
                REG_LINE_ADDR_1: line_addr_1_next = pwdata[LINE_W-1:0];
                REG_LINE_ADDR_2: line_addr_2_next = pwdata[LINE_W-1:0];
                default:         line_addr_3_next = pwdata[LINE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        push            = 1'b0;
        push_job.kind   = JOB_BYTE;
        push_job.rs     = 1'b0;
        push_job.data   = cmd.value;
        cursor_row_next = cursor_row_reg;
        case (mode_t'(cmd.mode))
            MODE_INIT:
            begin
                push            = accept;
                push_job.kind   = JOB_INIT;
                cursor_row_next = 2'd0;
            end
            MODE_CLEAR:
            begin
                push            = accept;
                push_job.kind   = JOB_CLEAR;
                cursor_row_next = 2'd0;
            end
            MODE_GOTO:
            begin
                push            = accept;
                push_job.data   = goto_byte;
                cursor_row_next = cmd.row;
            end
            MODE_CMD:
            begin
                push = accept;
            end
            MODE_DATA:
            begin
                push = accept;
                if (cmd.value == CHAR_NEWLINE)
                begin
                    push_job.data   = goto_byte;
                    cursor_row_next = wrap_row;
                end
                else
                begin
                    push_job.rs = 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        if (!accept)
        begin
            cursor_row_next = cursor_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_addr_0_reg <= LINE_ADDR_0_RST;
            line_addr_1_reg <= LINE_ADDR_1_RST;
            line_addr_2_reg <= LINE_ADDR_2_RST;
            line_addr_3_reg <= LINE_ADDR_3_RST;
            cursor_row_reg  <= 2'd0;
        end
        else
        begin
            line_addr_0_reg <= line_addr_0_next;
            line_addr_1_reg <= line_addr_1_next;
            line_addr_2_reg <= line_addr_2_next;
            line_addr_3_reg <= line_addr_3_next;
            cursor_row_reg  <= cursor_row_next;
        end
    end

endmodule

>>> src/clns_queue.sv
module clns_queue #(
    parameter int DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  clns_pkg::job_t push_job,
    output logic           full,
    output logic           head_valid,
    output clns_pkg::job_t head,
    input  logic           pop
);
    import clns_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/clns_back.sv
module clns_back (
    input  logic           clk,
    input  logic           rst_n,
    input  clns_pkg::job_t head,
    input  logic           head_valid,
    output logic           pop,
    output clns_pkg::evt_t evt,
    output logic           evt_valid,
    input  logic           evt_ready
);
    import clns_pkg::*;

    logic  busy_reg, busy_next;
    logic  evt_valid_reg, evt_valid_next;
    job_t  job_reg, job_next;
    step_t step_reg, step_next;
    evt_t  evt_reg, evt_next;

    job_t  cur_job;
    step_t cur_step;
    evt_t  cur_evt;
    logic  advance;
    logic  fire;

    assign cur_job  = busy_reg ? job_reg : head;
    assign cur_step = busy_reg ? step_reg :
                      ((head.kind == JOB_CLEAR) ? STEP_CLEAR : '0);
    assign cur_evt  = job_event(cur_job, cur_step);
    assign advance  = !evt_valid_reg || evt_ready;
    assign fire     = advance && (busy_reg || head_valid);
    assign pop      = fire && !busy_reg;

    assign evt       = evt_reg;
    assign evt_valid = evt_valid_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        evt_valid_next = evt_valid_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        evt_next       = evt_reg;
        if (advance)
        begin
            evt_valid_next = fire;
        end
        if (fire)
        begin
            busy_next = !cur_evt.last;
            job_next  = cur_job;
            step_next = cur_step + 1'b1;
            evt_next  = cur_evt;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        step_reg <= step_next;
        evt_reg  <= evt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

endmodule

>>> src/char_lcd_nibble_bus_sequencer_unit.sv
// Character LCD 4-bit bus sequencer.
// cmd channel (valid/ready): one request per item (init, clear, goto, command byte,
// data character). evt channel (valid/ready): the bus events for that request, with
// last set on the final one. Hold counts are carried out downstream.
// APB port: line start addresses of rows 0..3 at 0x0, 0x4, 0x8, 0xC; pready tied high.
// The first event of a request passes the request queue, then the event register.
// Throughput: one event per cycle while evt_ready is high and a request is pending;
// a byte request gives 4 events, clear 8, init 37. Goto and newline look up the line
// address in the front. Unused modes are taken and dropped with no events.
// Reset: line addresses 0x00, 0x40, 0x14, 0x54; cursor row 0; queue empty.
// When evt_ready is low the event register holds, the sequencer stops, the request
// queue fills and then cmd_ready drops.
module char_lcd_nibble_bus_sequencer_unit #(
    parameter int NUM_ROWS    = clns_pkg::NUM_ROWS_DEF,
    parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  clns_pkg::cmd_t                  cmd,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    output clns_pkg::evt_t                  evt,
    output logic                            evt_valid,
    input  logic                            evt_ready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clns_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [clns_pkg::APB_DATA_W-1:0] pwdata,
    output logic [clns_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import clns_pkg::*;

    logic q_push;
    job_t q_push_job;
    logic q_full;
    logic q_head_valid;
    job_t q_head;
    logic q_pop;

    assign pready = 1'b1;

    clns_front #(
        .NUM_ROWS (NUM_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .push       (q_push),
        .push_job   (q_push_job),
        .queue_full (q_full)
    );

    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    clns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .evt        (evt),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready)
    );

    // unused modes never reach the queue
    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready && (cmd.mode > MODE_DATA)) |-> !q_push)
        else $error("unused mode queued");

    // a request always ends on the enable falling edge
    a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.last) |-> !evt.enable)
        else $error("last event with enable high");

    // enable high is followed at once by enable low on the same nibble
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready && evt.enable) |=>
        (evt_valid && !evt.enable && (evt.nibble == $past(evt.nibble))
         && (evt.reg_select == $past(evt.reg_select))))
        else $error("enable strobe not closed");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import clns_pkg::*;

    localparam int ROWS        = NUM_ROWS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 8;

    localparam logic [2:0] SPARE_MODE_FIRST = MODE_DATA + 3'd1;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    cmd_t        cmd       = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    evt_t        evt;
    logic        evt_valid;
    logic        evt_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    cmd_t        pending_reqs[$];
    evt_t        bus_expect[$];
    line_addr_t  line_start[4];
    logic [1:0]  cur_row;
    evt_t        held_evt;
    logic        have_held;
    evt_t        want_evt;
    int          fail_count  = 0;
    int          idle_cycles = 0;
    logic        steady_run  = 1'b0;

    char_lcd_nibble_bus_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .evt       (evt),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // the newest event is held back so that last can be set on it
    task automatic put_event(input logic rs, input logic en, input logic [3:0] nib,
                             input logic [16:0] hold);
        if (have_held)
            bus_expect.push_back(held_evt);
        held_evt  = {rs, en, nib, hold, 1'b0};
        have_held = 1'b1;
    endtask

    task automatic put_byte(input logic rs, input logic [7:0] b, input logic [16:0] extra);
        put_event(rs, 1'b1, b[7:4], HOLD_HI_NIB);
        put_event(rs, 1'b0, b[7:4], HOLD_HI_NIB);
        put_event(rs, 1'b1, b[3:0], HOLD_LO_NIB);
        put_event(rs, 1'b0, b[3:0], HOLD_LO_NIB + HOLD_TAIL + extra);
    endtask

    task automatic put_pulse(input logic [3:0] nib);
        put_event(1'b0, 1'b1, nib, HOLD_PULSE);
        put_event(1'b0, 1'b0, nib, HOLD_PULSE + HOLD_GAP);
    endtask

    task automatic put_clear();
        put_byte(1'b0, CMD_CLEAR, HOLD_CLEAR);
        put_byte(1'b0, CMD_SET_DDRAM, 17'd0);
        cur_row = 2'd0;
    endtask

    task automatic put_goto(input logic [5:0] col, input logic [1:0] r);
        logic [7:0] addr;
        addr = {2'b00, col} + {1'b0, line_start[r]};
        put_byte(1'b0, CMD_SET_DDRAM | addr, 17'd0);
        cur_row = r;
    endtask

    task automatic plan_bus_events(input cmd_t c);
        int next_row;
        have_held = 1'b0;
        case (c.mode)
            MODE_INIT:
            begin
                put_event(1'b0, 1'b0, 4'h0, HOLD_PWR_UP);
                put_pulse(NIB_WAKE);
                put_pulse(NIB_WAKE);
                put_pulse(NIB_WAKE);
                put_pulse(NIB_4BIT);
                put_byte(1'b0, CMD_FUNC_SET, HOLD_GAP);
                put_byte(1'b0, CMD_DISP_OFF, HOLD_GAP);
                put_byte(1'b0, CMD_CLEAR, HOLD_GAP);
                put_byte(1'b0, CMD_DISP_ON, HOLD_GAP);
                put_byte(1'b0, CMD_ENTRY, HOLD_GAP);
                put_clear();
            end
            MODE_CLEAR:
                put_clear();
            MODE_GOTO:
                put_goto(c.column, c.row);
            MODE_CMD:
                put_byte(1'b0, c.value, 17'd0);
            MODE_DATA:
            begin
                if (c.value == CHAR_NEWLINE)
                begin
                    next_row = int'(cur_row) + 1;
                    if (next_row >= ROWS)
                        next_row = 0;
                    put_goto(6'd0, 2'(next_row));
                end
                else
                    put_byte(1'b1, c.value, 17'd0);
            end
            default:
                ;
        endcase
        if (have_held)
        begin
            held_evt.last = 1'b1;
            bus_expect.push_back(held_evt);
            have_held = 1'b0;
        end
    endtask

    function automatic cmd_t make_req(input logic [2:0] m, input logic [7:0] v,
                                      input logic [5:0] col, input logic [1:0] r);
        cmd_t c;
        c.mode   = m;
        c.value  = v;
        c.column = col;
        c.row    = r;
        return c;
    endfunction

    function automatic cmd_t random_req();
        cmd_t c;
        int   pick;
        c      = make_req(MODE_DATA, 8'($urandom), 6'($urandom), 2'($urandom));
        pick   = $urandom_range(99);
        if (pick < 3)
            c.mode = MODE_INIT;
        else if (pick < 10)
            c.mode = MODE_CLEAR;
        else if (pick < 35)
        begin
            c.mode = MODE_GOTO;
            if ($urandom_range(9) != 0)
                c.column = 6'($urandom_range(39));
        end
        else if (pick < 55)
            c.mode = MODE_CMD;
        else if (pick < 95)
        begin
            if ($urandom_range(6) == 0)
                c.value = CHAR_NEWLINE;
        end
        else
            c.mode = SPARE_MODE_FIRST + 3'($urandom_range(2));
        return c;
    endfunction

    task automatic reg_write(input reg_idx_t idx, input line_addr_t v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        line_start[idx] = v;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || cmd_valid || bus_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else if (!cmd_valid || cmd_ready)
        begin
            if (cmd_valid)
            begin
                plan_bus_events(cmd);
                void'(pending_reqs.pop_front());
            end
            if (pending_reqs.size() != 0 && (steady_run || $urandom_range(99) >= 32))
            begin
                cmd       <= pending_reqs[0];
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // event monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_ready <= 1'b0;
        else
        begin
            if (evt_valid && evt_ready)
            begin
                if (bus_expect.size() == 0)
                begin
                    $error("unexpected bus event %p", evt);
                    fail_count++;
                end
                else
                begin
                    want_evt = bus_expect.pop_front();
                    if (evt.reg_select !== want_evt.reg_select)
                    begin
                        $error("reg_select: expected %0d, got %0d",
                               want_evt.reg_select, evt.reg_select);
                        fail_count++;
                    end
                    if (evt.enable !== want_evt.enable)
                    begin
                        $error("enable: expected %0d, got %0d", want_evt.enable, evt.enable);
                        fail_count++;
                    end
                    if (evt.nibble !== want_evt.nibble)
                    begin
                        $error("nibble: expected %0d, got %0d", want_evt.nibble, evt.nibble);
                        fail_count++;
                    end
                    if (evt.hold_cycles !== want_evt.hold_cycles)
                    begin
                        $error("hold_cycles: expected %0d, got %0d",
                               want_evt.hold_cycles, evt.hold_cycles);
                        fail_count++;
                    end
                    if (evt.last !== want_evt.last)
                    begin
                        $error("last: expected %0d, got %0d", want_evt.last, evt.last);
                        fail_count++;
                    end
                end
            end
            evt_ready <= steady_run || $urandom_range(99) >= 32;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (evt_valid && evt_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        line_start[0] = LINE_ADDR_0_RST;
        line_start[1] = LINE_ADDR_1_RST;
        line_start[2] = LINE_ADDR_2_RST;
        line_start[3] = LINE_ADDR_3_RST;
        cur_row       = 2'd0;
        have_held     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at the reset line addresses
        pending_reqs.push_back(make_req(MODE_INIT, 8'h00, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_CMD, 8'h00, 6'd63, 2'd3));
        pending_reqs.push_back(make_req(MODE_CMD, 8'hFF, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_CMD, CHAR_NEWLINE, 6'd21, 2'd2));
        pending_reqs.push_back(make_req(MODE_DATA, 8'h00, 6'd42, 2'd1));
        pending_reqs.push_back(make_req(MODE_DATA, 8'hFF, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_DATA, 8'h55, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_DATA, 8'hAA, 6'd63, 2'd3));
        // newline walks every row and wraps back to the top
        repeat (4)
            pending_reqs.push_back(make_req(MODE_DATA, CHAR_NEWLINE, 6'd17, 2'd2));
        pending_reqs.push_back(make_req(MODE_GOTO, 8'h00, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_GOTO, 8'hFF, 6'd39, 2'd3));
        pending_reqs.push_back(make_req(MODE_GOTO, 8'h00, 6'd63, 2'd3));
        pending_reqs.push_back(make_req(MODE_GOTO, 8'h00, 6'd63, 2'd1));
        pending_reqs.push_back(make_req(MODE_GOTO, 8'h00, 6'd5, 2'd2));
        pending_reqs.push_back(make_req(MODE_DATA, CHAR_NEWLINE, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(SPARE_MODE_FIRST, 8'hFF, 6'd63, 2'd3));
        pending_reqs.push_back(make_req(SPARE_MODE_FIRST + 3'd1, 8'h00, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(SPARE_MODE_FIRST + 3'd2, CHAR_NEWLINE, 6'd7, 2'd1));
        pending_reqs.push_back(make_req(MODE_DATA, CHAR_NEWLINE, 6'd0, 2'd0));
        pending_reqs.push_back(make_req(MODE_CLEAR, 8'hFF, 6'd63, 2'd3));
        pending_reqs.push_back(make_req(MODE_DATA, CHAR_NEWLINE, 6'd0, 2'd0));
        wait_drained();

        for (int phase = 1; phase <= 5; phase++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case (phase)
                    1:       reg_write(reg_idx_t'(i), (i % 2 == 0) ? 7'd0 : 7'd127);
                    2:       reg_write(reg_idx_t'(i), 7'd127);
                    3:       reg_write(reg_idx_t'(i), 7'd0);
                    4:       reg_write(reg_idx_t'(i), 7'($urandom_range(127)));
                    default: reg_write(reg_idx_t'(i), (i == 0) ? LINE_ADDR_0_RST :
                                                      (i == 1) ? LINE_ADDR_1_RST :
                                                      (i == 2) ? LINE_ADDR_2_RST :
                                                                 LINE_ADDR_3_RST);
                endcase
            end
            @(negedge clk);
            // one phase runs with no gaps on either side
            steady_run = (phase == 2);
            repeat ((phase <= 3) ? 60 : 70)
                pending_reqs.push_back(random_req());
            wait_drained();
            steady_run = 1'b0;
        end

        repeat (12) @(negedge clk);
        if (fail_count == 0 && bus_expect.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
src/clns_pkg.sv
src/clns_front.sv
src/clns_queue.sv
src/clns_back.sv
src/char_lcd_nibble_bus_sequencer_unit.sv
tb/sv/testbench.sv
